>>> rtl/lrtd_pkg.sv
// Shared types and constants for the lens distortion pipeline.
package lrtd_pkg;

  localparam int NORM_W     = 27;
  localparam int Q_BITS     = 26;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = Q_BITS / DIV_STEPS;
  localparam int SCALE_W    = 36;
  localparam int DR_W       = 51;

  localparam logic signed [NORM_W-1:0]  NORM_MAX  = 27'sd67108863;
  localparam logic signed [SCALE_W-1:0] SCALE_MAX = 36'sd34359738367;
  localparam logic signed [DR_W-1:0]    ONE_Q28   = 51'sd268435456;

  typedef struct packed {
    logic valid;
    logic clip;
  } flag_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_PRINCIPAL = 3'd2,
    REG_K1        = 3'd3,
    REG_K2        = 3'd4,
    REG_K3        = 3'd5,
    REG_P1        = 3'd6,
    REG_P2        = 3'd7
  } cfg_reg_t;

endpackage

>>> rtl/lrtd_norm.sv
// Normalization of one axis: offset, overflow check and pipelined restoring divider.
module lrtd_norm import lrtd_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          vld_in,
  input  logic signed [COORD_WIDTH-1:0] coord_in,
  input  logic signed [31:0]            center,
  input  logic [31:0]                   focal,
  output logic signed [NORM_W-1:0]      coord_o,
  output flag_t                         flag_o
);

  logic signed [33:0] d_r;
  logic               v1_r;
  logic [31:0]        rem0_r;
  logic               neg0_r, sat0_r, zero0_r, v2_r;

  logic [31:0]       rem_r  [DIV_STAGES];
  logic [Q_BITS-1:0] q_r    [DIV_STAGES];
  logic              neg_r  [DIV_STAGES];
  logic              sat_r  [DIV_STAGES];
  logic              zero_r [DIV_STAGES];
  logic              vld_r  [DIV_STAGES];

  logic [31:0]       rem_src  [DIV_STAGES];
  logic [Q_BITS-1:0] q_src    [DIV_STAGES];
  logic [31:0]       rem_nxt  [DIV_STAGES];
  logic [Q_BITS-1:0] q_nxt    [DIV_STAGES];

  logic signed [33:0]        d_nxt;
  logic [33:0]               m_w;
  logic                      ovf_w;
  logic signed [NORM_W-1:0]  x_nxt;
  logic signed [NORM_W-1:0]  x_r;
  flag_t                     flag_r;

  assign d_nxt = {{(34-COORD_WIDTH){coord_in[COORD_WIDTH-1]}}, coord_in}
               - {{2{center[31]}}, center};
  assign m_w   = d_r[33] ? 34'(-d_r) : 34'(d_r);
  assign ovf_w = {m_w, 6'b0} >= {8'b0, focal};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r     <= d_nxt;
      rem0_r  <= {m_w[25:0], 6'b0};
      neg0_r  <= d_r[33];
      sat0_r  <= ovf_w;
      zero0_r <= (focal == 32'd0);
    end
  end

  always_comb begin
    rem_src[0] = rem0_r;
    q_src[0]   = '0;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_src[s] = rem_r[s-1];
      q_src[s]   = q_r[s-1];
    end
  end

  always_comb begin
    logic [32:0] sh;
    sh = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_nxt[s] = rem_src[s];
      q_nxt[s]   = q_src[s];
      for (int i = 0; i < DIV_STEPS; i++) begin
        sh = {rem_nxt[s], 1'b0};
        if (sh >= {1'b0, focal}) begin
          rem_nxt[s] = 32'(sh - {1'b0, focal});
          q_nxt[s]   = {q_nxt[s][Q_BITS-2:0], 1'b1};
        end else begin
          rem_nxt[s] = sh[31:0];
          q_nxt[s]   = {q_nxt[s][Q_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= v2_r;
      for (int s = 1; s < DIV_STAGES; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
      neg_r[0]  <= neg0_r;
      sat_r[0]  <= sat0_r;
      zero_r[0] <= zero0_r;
      for (int s = 1; s < DIV_STAGES; s++) begin
        neg_r[s]  <= neg_r[s-1];
        sat_r[s]  <= sat_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end
    end
  end

  always_comb begin
    if (zero_r[DIV_STAGES-1]) begin
      x_nxt = '0;
    end else if (sat_r[DIV_STAGES-1]) begin
      x_nxt = neg_r[DIV_STAGES-1] ? -NORM_MAX : NORM_MAX;
    end else if (neg_r[DIV_STAGES-1]) begin
      x_nxt = -$signed({1'b0, q_r[DIV_STAGES-1]});
    end else begin
      x_nxt = $signed({1'b0, q_r[DIV_STAGES-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r.valid <= 1'b0;
    end else if (adv) begin
      flag_r.valid <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r         <= x_nxt;
      flag_r.clip <= sat_r[DIV_STAGES-1] && !zero_r[DIV_STAGES-1];
    end
  end

  assign coord_o = x_r;
  assign flag_o  = flag_r;

endmodule

>>> rtl/lrtd_radial.sv
// Radial factor pipeline: squares, powers of r squared and the saturated scale.
module lrtd_radial import lrtd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  flag_t                      flag_in,
  input  logic signed [NORM_W-1:0]   x_in,
  input  logic signed [NORM_W-1:0]   y_in,
  input  logic signed [31:0]         k1,
  input  logic signed [31:0]         k2,
  input  logic signed [31:0]         k3,
  output logic signed [NORM_W-1:0]   x_o,
  output logic signed [NORM_W-1:0]   y_o,
  output logic signed [29:0]         xy_o,
  output logic signed [31:0]         rx_o,
  output logic signed [31:0]         ry_o,
  output logic signed [SCALE_W-1:0]  scale_o,
  output flag_t                      flag_o
);

  localparam int NST = 7;

  logic  vld_r [NST];
  logic  clip_r [NST];

  logic signed [NORM_W-1:0] x1_r, y1_r, x2c_r, y2c_r, x3_r, y3_r, x4_r, y4_r;
  logic signed [NORM_W-1:0] x5_r, y5_r, x6_r, y6_r, x7_r, y7_r;
  logic signed [53:0] xx_r, yy_r, xyp_r;
  logic signed [29:0] sx2_r, sy2_r, xy2_r, xy3_r, xy4_r, xy5_r, xy6_r, xy7_r;
  logic signed [30:0] r2_r, r2b_r;
  logic signed [61:0] r2sq_r;
  logic signed [62:0] kr2_r, kr2b_r, kr2c_r;
  logic signed [31:0] rx3_r, ry3_r, rx4_r, ry4_r, rx5_r, ry5_r, rx6_r, ry6_r, rx7_r, ry7_r;
  logic signed [62:0] r4r2_r;
  logic signed [63:0] k2r4_r, k2r4b_r, k3r6_r;
  logic signed [DR_W-1:0]    sum_r;
  logic signed [SCALE_W-1:0] scale_r;

  logic signed [29:0] sx2_w, sy2_w;
  logic signed [31:0] r4_w, r6_w;
  logic signed [DR_W-1:0] t1_w, t2_w, t3_w;
  logic sat_hi_w, sat_lo_w;

  assign sx2_w = xx_r[53:24];
  assign sy2_w = yy_r[53:24];
  assign r4_w  = r2sq_r[59:28];
  assign r6_w  = r4r2_r[59:28];
  assign t1_w  = DR_W'($signed(kr2c_r[62:24]));
  assign t2_w  = DR_W'($signed(k2r4b_r[63:20]));
  assign t3_w  = DR_W'($signed(k3r6_r[63:16]));
  assign sat_hi_w = sum_r > DR_W'(SCALE_MAX);
  assign sat_lo_w = sum_r < -DR_W'(SCALE_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= flag_in.valid;
      for (int s = 1; s < NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clip_r[0] <= flag_in.clip;
      for (int s = 1; s < NST - 1; s++) clip_r[s] <= clip_r[s-1];
      clip_r[NST-1] <= clip_r[NST-2] || sat_hi_w || sat_lo_w;

      x1_r  <= x_in;
      y1_r  <= y_in;
      xx_r  <= x_in * x_in;
      yy_r  <= y_in * y_in;
      xyp_r <= x_in * y_in;

      x2c_r <= x1_r;
      y2c_r <= y1_r;
      sx2_r <= sx2_w;
      sy2_r <= sy2_w;
      xy2_r <= xyp_r[53:24];
      r2_r  <= 31'(sx2_w) + 31'(sy2_w);

      x3_r   <= x2c_r;
      y3_r   <= y2c_r;
      xy3_r  <= xy2_r;
      r2b_r  <= r2_r;
      r2sq_r <= r2_r * r2_r;
      kr2_r  <= k1 * r2_r;
      rx3_r  <= 32'(r2_r) + (32'(sx2_r) <<< 1);
      ry3_r  <= 32'(r2_r) + (32'(sy2_r) <<< 1);

      x4_r   <= x3_r;
      y4_r   <= y3_r;
      xy4_r  <= xy3_r;
      rx4_r  <= rx3_r;
      ry4_r  <= ry3_r;
      kr2b_r <= kr2_r;
      r4r2_r <= r4_w * r2b_r;
      k2r4_r <= k2 * r4_w;

      x5_r    <= x4_r;
      y5_r    <= y4_r;
      xy5_r   <= xy4_r;
      rx5_r   <= rx4_r;
      ry5_r   <= ry4_r;
      kr2c_r  <= kr2b_r;
      k2r4b_r <= k2r4_r;
      k3r6_r  <= k3 * r6_w;

      x6_r  <= x5_r;
      y6_r  <= y5_r;
      xy6_r <= xy5_r;
      rx6_r <= rx5_r;
      ry6_r <= ry5_r;
      sum_r <= ONE_Q28 + t1_w + t2_w + t3_w;

      x7_r  <= x6_r;
      y7_r  <= y6_r;
      xy7_r <= xy6_r;
      rx7_r <= rx6_r;
      ry7_r <= ry6_r;
      if (sat_hi_w) begin
        scale_r <= SCALE_MAX;
      end else if (sat_lo_w) begin
        scale_r <= -SCALE_MAX;
      end else begin
        scale_r <= sum_r[SCALE_W-1:0];
      end
    end
  end

  assign x_o          = x7_r;
  assign y_o          = y7_r;
  assign xy_o         = xy7_r;
  assign rx_o         = rx7_r;
  assign ry_o         = ry7_r;
  assign scale_o      = scale_r;
  assign flag_o.valid = vld_r[NST-1];
  assign flag_o.clip  = clip_r[NST-1];

endmodule

>>> rtl/lrtd_proj.sv
// Distortion sum and projection back to pixels for one axis, with output saturation.
module lrtd_proj import lrtd_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  flag_t                         flag_in,
  input  logic signed [NORM_W-1:0]      coord,
  input  logic signed [SCALE_W-1:0]     scale,
  input  logic signed [29:0]            xy,
  input  logic signed [31:0]            rterm,
  input  logic signed [31:0]            coef_cross,
  input  logic signed [31:0]            coef_r,
  input  logic [31:0]                   focal,
  input  logic signed [31:0]            center,
  output logic signed [COORD_WIDTH-1:0] dist_o,
  output flag_t                         flag_o
);

  localparam int NST = 6;
  localparam logic signed [39:0] HI = (40'sd1 <<< (COORD_WIDTH - 1)) - 40'sd1;
  localparam logic signed [39:0] LO = -HI - 40'sd1;

  logic vld_r  [NST];
  logic clip_r [NST];

  logic signed [62:0] t0_r;
  logic signed [61:0] t1_r;
  logic signed [63:0] t2_r;
  logic signed [63:0] xd_r;
  logic [35:0]        m_r;
  logic               neg3_r, neg4_r, neg5_r;
  logic [51:0]        a_r, b_r;
  logic [36:0]        p_r;
  logic signed [COORD_WIDTH-1:0] dist_r;

  logic signed [63:0] e0_w, e1_w;
  logic signed [35:0] n_w;
  logic [52:0]        ab_w;
  logic signed [39:0] sp_w, r_w;
  logic               hi_w, lo_w;

  assign e0_w = t0_r;
  assign e1_w = t1_r;
  assign n_w  = xd_r[63:28];
  assign ab_w = {1'b0, a_r} + {17'b0, b_r[51:16]};
  assign sp_w = neg5_r ? -$signed({3'b0, p_r}) : $signed({3'b0, p_r});
  assign r_w  = sp_w + 40'(center);
  assign hi_w = r_w > HI;
  assign lo_w = r_w < LO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= flag_in.valid;
      for (int s = 1; s < NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clip_r[0] <= flag_in.clip;
      for (int s = 1; s < NST - 1; s++) clip_r[s] <= clip_r[s-1];
      clip_r[NST-1] <= clip_r[NST-2] || hi_w || lo_w;

      t0_r <= coord * scale;
      t1_r <= coef_cross * xy;
      t2_r <= coef_r * rterm;

      xd_r <= e0_w + (e1_w <<< 1) + t2_r;

      neg3_r <= n_w[35];
      m_r    <= n_w[35] ? 36'(-n_w) : 36'(n_w);

      neg4_r <= neg3_r;
      a_r    <= m_r * focal[31:16];
      b_r    <= m_r * focal[15:0];

      neg5_r <= neg4_r;
      p_r    <= ab_w[52:16];

      if (hi_w) begin
        dist_r <= HI[COORD_WIDTH-1:0];
      end else if (lo_w) begin
        dist_r <= LO[COORD_WIDTH-1:0];
      end else begin
        dist_r <= r_w[COORD_WIDTH-1:0];
      end
    end
  end

  assign dist_o       = dist_r;
  assign flag_o.valid = vld_r[NST-1];
  assign flag_o.clip  = clip_r[NST-1];

endmodule

>>> rtl/lens_radial_tangential_distort_core.sv
// Top level of the five-coefficient radial and tangential lens distortion pipeline.
//
// Each input transaction carries one undistorted pixel coordinate pair (pix_u, pix_v)
// in signed Q16.8; each output transaction carries the distorted pair and a clipped
// flag that is set when any intermediate or final value was saturated.
// Both channels use valid and stall; a transaction moves when valid is high and
// stall is low. The camera matrix and coefficients are written through the plain
// cfg port; the user must write them only while no transaction is in flight, as
// the block itself does not enforce this. Normalization uses the restoring divider
// that resolves two quotient bits per stage, followed by the radial factor and the
// projection back to pixels. One transaction is accepted in every cycle in which
// the pipeline is not held by a stall.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all pipeline valid bits and loads the identity camera with no
// distortion.
module lens_radial_tangential_distort_core import lrtd_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [63:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pix_u,
  input  logic signed [COORD_WIDTH-1:0] in_pix_v,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_dist_u,
  output logic signed [COORD_WIDTH-1:0] out_dist_v,
  output logic                          out_clipped
);

  logic [31:0] focal_x_r, focal_y_r;
  logic [63:0] principal_r;
  logic [31:0] k1_r, k2_r, k3_r, p1_r, p2_r;

  logic adv;
  logic signed [NORM_W-1:0]  nx_coord, ny_coord, rx_coord, ry_coord;
  flag_t                     nx_flag, ny_flag, rad_flag, rad_in_flag, px_flag, py_flag;
  flag_t                     py_in_flag;
  logic signed [29:0]        rad_xy;
  logic signed [31:0]        rad_rx, rad_ry;
  logic signed [SCALE_W-1:0] rad_scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r   <= 32'd65536;
      focal_y_r   <= 32'd65536;
      principal_r <= '0;
      k1_r        <= '0;
      k2_r        <= '0;
      k3_r        <= '0;
      p1_r        <= '0;
      p2_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:   focal_x_r   <= cfg_wdata[31:0];
        REG_FOCAL_Y:   focal_y_r   <= cfg_wdata[31:0];
        REG_PRINCIPAL: principal_r <= cfg_wdata;
        REG_K1:        k1_r        <= cfg_wdata[31:0];
        REG_K2:        k2_r        <= cfg_wdata[31:0];
        REG_K3:        k3_r        <= cfg_wdata[31:0];
        REG_P1:        p1_r        <= cfg_wdata[31:0];
        REG_P2:        p2_r        <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(px_flag.valid && out_stall);
  assign in_stall = !adv;

  lrtd_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm_x (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_in(in_valid), .coord_in(in_pix_u),
    .center(principal_r[31:0]), .focal(focal_x_r), .coord_o(nx_coord), .flag_o(nx_flag)
  );

  lrtd_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm_y (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_in(in_valid), .coord_in(in_pix_v),
    .center(principal_r[63:32]), .focal(focal_y_r), .coord_o(ny_coord), .flag_o(ny_flag)
  );

  assign rad_in_flag.valid = nx_flag.valid;
  assign rad_in_flag.clip  = nx_flag.clip || ny_flag.clip;

  lrtd_radial u_radial (
    .clk(clk), .rst_n(rst_n), .adv(adv), .flag_in(rad_in_flag),
    .x_in(nx_coord), .y_in(ny_coord), .k1(k1_r), .k2(k2_r), .k3(k3_r),
    .x_o(rx_coord), .y_o(ry_coord), .xy_o(rad_xy), .rx_o(rad_rx), .ry_o(rad_ry),
    .scale_o(rad_scale), .flag_o(rad_flag)
  );

  assign py_in_flag.valid = rad_flag.valid;
  assign py_in_flag.clip  = 1'b0;

  lrtd_proj #(.COORD_WIDTH(COORD_WIDTH)) u_proj_x (
    .clk(clk), .rst_n(rst_n), .adv(adv), .flag_in(rad_flag),
    .coord(rx_coord), .scale(rad_scale), .xy(rad_xy), .rterm(rad_rx),
    .coef_cross(p1_r), .coef_r(p2_r), .focal(focal_x_r), .center(principal_r[31:0]),
    .dist_o(out_dist_u), .flag_o(px_flag)
  );

  lrtd_proj #(.COORD_WIDTH(COORD_WIDTH)) u_proj_y (
    .clk(clk), .rst_n(rst_n), .adv(adv), .flag_in(py_in_flag),
    .coord(ry_coord), .scale(rad_scale), .xy(rad_xy), .rterm(rad_ry),
    .coef_cross(p2_r), .coef_r(p1_r), .focal(focal_y_r), .center(principal_r[63:32]),
    .dist_o(out_dist_v), .flag_o(py_flag)
  );

  assign out_valid   = px_flag.valid;
  assign out_clipped = px_flag.clip || py_flag.clip;

  a_norm_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    nx_flag.valid == ny_flag.valid)
    else $error("normalization lanes out of step");

  a_proj_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    px_flag.valid == py_flag.valid)
    else $error("projection lanes out of step");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(rad_flag.valid) && $stable(nx_flag.valid))
    else $error("pipeline moved while output stalled");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the radial and tangential lens distortion pipeline.
`timescale 1ns / 1ps

module tb;
  import lrtd_pkg::*;

  localparam int CW = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 200;

  typedef struct {
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
  } pixel_t;

  typedef struct {
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
    logic                 clip;
  } distorted_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [63:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_pix_u = '0;
  logic signed [CW-1:0] in_pix_v = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] out_dist_u;
  logic signed [CW-1:0] out_dist_v;
  logic                 out_clipped;

  logic [31:0]        focal_x_q = 32'd65536;
  logic [31:0]        focal_y_q = 32'd65536;
  logic [63:0]        principal_q = '0;
  logic signed [31:0] k1_q = '0;
  logic signed [31:0] k2_q = '0;
  logic signed [31:0] k3_q = '0;
  logic signed [31:0] p1_q = '0;
  logic signed [31:0] p2_q = '0;

  pixel_t     pending_pixels[$];
  distorted_t expected_points[$];
  bit         quiet = 1'b0;
  int         pixels_sent = 0;
  int         points_seen = 0;
  int         clipped_seen = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  bit         long_hold_done = 1'b0;

  lens_radial_tangential_distort_core #(.COORD_WIDTH(CW)) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_pix_u(in_pix_u), .in_pix_v(in_pix_v),
    .out_valid(out_valid), .out_stall(out_stall), .out_dist_u(out_dist_u),
    .out_dist_v(out_dist_v), .out_clipped(out_clipped)
  );

  always #5 clk = ~clk;

  function automatic longint normalize_axis(longint d, longint unsigned f, inout bit clip);
    longint unsigned m;
    longint q;
    if (f == 0) return 0;
    m = (d < 0) ? longint'(-d) : longint'(d);
    if ((m << 6) >= f) begin
      q = NORM_MAX;
      clip = 1'b1;
    end else begin
      q = longint'((m << 32) / f);
    end
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic signed [CW-1:0] project_axis(longint xd, longint unsigned f,
                                                        longint c, inout bit clip);
    longint n;
    longint unsigned m;
    longint unsigned a;
    longint unsigned b;
    longint p;
    longint r;
    longint hi;
    n = xd >>> 28;
    m = (n < 0) ? longint'(-n) : longint'(n);
    a = m * (f >> 16);
    b = m * (f & 64'hFFFF);
    p = longint'((a + (b >> 16)) >> 16);
    hi = (longint'(1) << (CW - 1)) - 1;
    r = ((n < 0) ? -p : p) + c;
    if (r > hi) begin
      r = hi;
      clip = 1'b1;
    end
    if (r < -hi - 1) begin
      r = -hi - 1;
      clip = 1'b1;
    end
    return r[CW-1:0];
  endfunction

  function automatic distorted_t distort_pixel(logic signed [CW-1:0] pu,
                                               logic signed [CW-1:0] pv);
    distorted_t res;
    bit clip;
    longint cx, cy, x, y, x2, y2, xy, r2, r4, r6, dr, scale, xd, yd;
    longint k1, k2, k3, p1, p2;
    clip = 1'b0;
    cx = longint'($signed(principal_q[31:0]));
    cy = longint'($signed(principal_q[63:32]));
    k1 = longint'(k1_q);
    k2 = longint'(k2_q);
    k3 = longint'(k3_q);
    p1 = longint'(p1_q);
    p2 = longint'(p2_q);
    x = normalize_axis(longint'(pu) - cx, longint'(focal_x_q), clip);
    y = normalize_axis(longint'(pv) - cy, longint'(focal_y_q), clip);
    x2 = (x * x) >>> 24;
    y2 = (y * y) >>> 24;
    xy = (x * y) >>> 24;
    r2 = x2 + y2;
    r4 = (r2 * r2) >>> 28;
    r6 = (r4 * r2) >>> 28;
    dr = ((k1 * r2) >>> 24) + ((k2 * r4) >>> 20) + ((k3 * r6) >>> 16);
    scale = longint'(ONE_Q28) + dr;
    if (scale > longint'(SCALE_MAX)) begin
      scale = SCALE_MAX;
      clip = 1'b1;
    end
    if (scale < -longint'(SCALE_MAX)) begin
      scale = -longint'(SCALE_MAX);
      clip = 1'b1;
    end
    xd = x * scale + 2 * (p1 * xy) + p2 * (r2 + 2 * x2);
    yd = y * scale + p1 * (r2 + 2 * y2) + 2 * (p2 * xy);
    res.u = project_axis(xd, longint'(focal_x_q), cx, clip);
    res.v = project_axis(yd, longint'(focal_y_q), cy, clip);
    res.clip = clip;
    return res;
  endfunction

  // Input side: presents queued pixels, holds them while stalled, inserts random gaps.
  always @(posedge clk) begin
    pixel_t px;
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_points.push_back(distort_pixel(in_pix_u, in_pix_v));
        pixels_sent++;
      end
      if (!(in_valid && in_stall)) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 9);
        end else if (pending_pixels.size() > 0) begin
          px = pending_pixels.pop_front();
          in_pix_u <= px.u;
          in_pix_v <= px.v;
          nv = 1'b1;
        end
        in_valid <= nv;
      end
    end
  end

  // Output side: checks every transaction and drives random and long stalls.
  always @(posedge clk) begin
    distorted_t exp_pt;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        points_seen++;
        if (out_clipped) clipped_seen++;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected transaction u=%0d v=%0d clip=%0b",
                     out_dist_u, out_dist_v, out_clipped);
        end else begin
          exp_pt = expected_points.pop_front();
          if (out_dist_u !== exp_pt.u || out_dist_v !== exp_pt.v ||
              out_clipped !== exp_pt.clip) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: expected u=%0d v=%0d clip=%0b, got u=%0d v=%0d clip=%0b",
                       exp_pt.u, exp_pt.v, exp_pt.clip, out_dist_u, out_dist_v,
                       out_clipped);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && points_seen >= 300) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    case (idx)
      REG_FOCAL_X:   focal_x_q = val[31:0];
      REG_FOCAL_Y:   focal_y_q = val[31:0];
      REG_PRINCIPAL: principal_q = val;
      REG_K1:        k1_q = val[31:0];
      REG_K2:        k2_q = val[31:0];
      REG_K3:        k3_q = val[31:0];
      REG_P1:        p1_q = val[31:0];
      REG_P2:        p2_q = val[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(logic [31:0] fx, logic [31:0] fy, logic [63:0] pp,
                            logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                            logic [31:0] p1, logic [31:0] p2);
    write_reg(REG_FOCAL_X, {32'd0, fx});
    write_reg(REG_FOCAL_Y, {32'd0, fy});
    write_reg(REG_PRINCIPAL, pp);
    write_reg(REG_K1, {32'd0, k1});
    write_reg(REG_K2, {32'd0, k2});
    write_reg(REG_K3, {32'd0, k3});
    write_reg(REG_P1, {32'd0, p1});
    write_reg(REG_P2, {32'd0, p2});
  endtask

  task automatic queue_pixel(int u, int v);
    pixel_t px;
    @(negedge clk);
    px.u = u[CW-1:0];
    px.v = v[CW-1:0];
    pending_pixels.push_back(px);
  endtask

  task automatic drain;
    while (pending_pixels.size() != 0 || expected_points.size() != 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic int random_coord(logic [31:0] c);
    int spread;
    if ($urandom_range(0, 9) < 7) begin
      spread = $urandom_range(0, 2000 << 8);
      return int'($signed(c)) + spread - (1000 << 8);
    end
    return int'($urandom);
  endfunction

  function automatic logic [31:0] random_coeff();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'd0;
      default: return $urandom_range(0, 134217728) - 67108864;
    endcase
  endfunction

  function automatic logic [31:0] random_focal();
    case ($urandom_range(0, 5))
      0: return $urandom | 32'd1;
      1: return $urandom_range(1, 65535);
      default: return $urandom_range(100 << 16, 2000 << 16);
    endcase
  endfunction

  function automatic logic [31:0] random_center();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 1920 << 8);
  endfunction

  initial begin
    int lo, hi;
    lo = -(1 << (CW - 1));
    hi = (1 << (CW - 1)) - 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity camera after reset; the normalized clip starts 4 pixels out.
    queue_pixel(0, 0);
    queue_pixel(1, -1);
    queue_pixel(1023, -1023);
    queue_pixel(1024, -1024);
    queue_pixel(hi, hi);
    queue_pixel(lo, lo);
    queue_pixel(hi, lo);
    drain();

    // Typical VGA camera with barrel distortion.
    set_camera(32'd500 << 16, 32'd500 << 16, {32'd240 << 8, 32'd320 << 8},
               -32'sd80530636, 32'sd26843546, -32'sd2684355, 32'sd268435, -32'sd134218);
    queue_pixel(0, 0);
    queue_pixel(640 << 8, 480 << 8);
    queue_pixel(320 << 8, 240 << 8);
    repeat (200)
      queue_pixel(random_coord(principal_q[31:0]), random_coord(principal_q[63:32]));
    drain();

    // Register extremes drive radial and output saturation.
    set_camera(32'hFFFF_FFFF, 32'd1, {32'h7FFF_FFFF, 32'h8000_0000},
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_pixel(0, 0);
    queue_pixel(hi, lo);
    queue_pixel(lo, hi);
    queue_pixel(-1, 1);
    drain();
    set_camera(32'd200 << 16, 32'd300 << 16, {32'd100 << 8, 32'd50 << 8},
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_pixel(hi, hi);
    queue_pixel(400 << 8, 350 << 8);
    queue_pixel(lo, 0);
    drain();

    // A zero focal length pins that axis to the principal point.
    set_camera(32'd0, 32'd0, {32'd77 << 8, 32'd33 << 8},
               32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_pixel(hi, lo);
    queue_pixel(5, 7);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      set_camera(random_focal(), random_focal(), {random_center(), random_center()},
                 random_coeff(), random_coeff(), random_coeff(), random_coeff(),
                 random_coeff());
      if (ph == 6) quiet = 1'b1;
      repeat (200)
        queue_pixel(random_coord(principal_q[31:0]), random_coord(principal_q[63:32]));
      drain();
    end

    $display("Summary: %0d pixels sent, %0d distorted points checked, %0d of them clipped,",
             pixels_sent, points_seen, clipped_seen);
    $display("  across identity, typical, extreme, zero-focal and random cameras.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
